### rtl/uapq_pkg.sv
// Shared constants, codes and control structs of the unsorted-array priority queue.
`default_nettype none
package uapq_pkg;

  localparam int DEPTH     = 8;
  localparam int PRIO_BITS = 8;
  localparam int VAL_BITS  = 32;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // capture the input beat, clear the scan index
    logic scan;    // compare one held entry against the running minimum
    logic shift;   // move one older entry up by one slot
    logic commit;  // update count and store, load the result register
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic del_go;      // captured beat is a delete and the queue holds entries
    logic scan_last;   // scan index points at the newest entry
    logic shift_done;  // shift index reached the oldest slot
    logic out_free;    // result register can take a new beat
  } dp_status_t;

  // Physical slot of the entry at a given age offset from the oldest slot.
  function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] oldest,
                                               input logic [IDX_W-1:0] offset);
    logic [IDX_W:0] sum;
    sum = {1'b0, oldest} + {1'b0, offset};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

### rtl/uapq_datapath.sv
// Datapath: entry store, scan and shift index, running minimum and result register.
`default_nettype none
module uapq_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd,
  input  wire logic signed [31:0]   value,
  input  wire logic [7:0]           priority_req,
  input  wire logic                 out_ready,
  input  wire uapq_pkg::dp_cmd_t    dp_cmd,
  output uapq_pkg::dp_status_t      dp_status,
  output logic [1:0]                status,
  output logic signed [31:0]        removed_value,
  output logic [7:0]                removed_priority,
  output logic [3:0]                occupancy,
  output logic                      out_valid
);

  logic [uapq_pkg::VAL_BITS-1:0]  value_store    [uapq_pkg::DEPTH];
  logic [uapq_pkg::PRIO_BITS-1:0] priority_store [uapq_pkg::DEPTH];

  logic [uapq_pkg::IDX_W-1:0] oldest_slot;
  logic [uapq_pkg::CNT_W-1:0] entry_count;

  // Captured beat.
  uapq_pkg::cmd_t                 cmd_q;
  logic [uapq_pkg::VAL_BITS-1:0]  val_q;
  logic [uapq_pkg::PRIO_BITS-1:0] pri_q;

  logic [uapq_pkg::IDX_W-1:0]     idx;
  logic [uapq_pkg::IDX_W-1:0]     best_idx;
  logic [uapq_pkg::PRIO_BITS-1:0] best_pri;
  logic [uapq_pkg::VAL_BITS-1:0]  best_val;

  logic [uapq_pkg::IDX_W-1:0]     scan_slot;
  logic [uapq_pkg::IDX_W-1:0]     src_slot;
  logic [uapq_pkg::IDX_W-1:0]     tail_slot;
  logic [uapq_pkg::IDX_W-1:0]     next_oldest;
  logic                           take;
  logic [uapq_pkg::IDX_W-1:0]     best_idx_next;
  logic                           full;
  logic                           empty;

  assign scan_slot   = uapq_pkg::slot_at(oldest_slot, idx);
  assign src_slot    = uapq_pkg::slot_at(oldest_slot, idx - uapq_pkg::IDX_W'(1));
  assign tail_slot   = uapq_pkg::slot_at(oldest_slot, entry_count[uapq_pkg::IDX_W-1:0]);
  assign next_oldest = uapq_pkg::slot_at(oldest_slot, uapq_pkg::IDX_W'(1));
  assign full        = (entry_count == uapq_pkg::CNT_W'(uapq_pkg::DEPTH));
  assign empty       = (entry_count == '0);

  // Strict less-than keeps the oldest entry on a tie.
  assign take          = (idx == '0) || (priority_store[scan_slot] < best_pri);
  assign best_idx_next = take ? idx : best_idx;

  assign dp_status.del_go     = (cmd_q == uapq_pkg::CMD_DELETE) && !empty;
  assign dp_status.scan_last  = (uapq_pkg::CNT_W'(idx) + uapq_pkg::CNT_W'(1)) == entry_count;
  assign dp_status.shift_done = (idx == '0);
  assign dp_status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_q <= uapq_pkg::cmd_t'(cmd);
      val_q <= value;
      pri_q <= priority_req[uapq_pkg::PRIO_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      idx <= '0;
    end else if (dp_cmd.scan) begin
      if (take) begin
        best_pri <= priority_store[scan_slot];
        best_val <= value_store[scan_slot];
      end
      best_idx <= best_idx_next;
      // On the newest entry, hand the winner's offset to the shift pass.
      idx <= dp_status.scan_last ? best_idx_next : idx + uapq_pkg::IDX_W'(1);
    end else if (dp_cmd.shift && !dp_status.shift_done) begin
      idx <= idx - uapq_pkg::IDX_W'(1);
    end
  end

  // Single write port: gap closing during shift, append on insert commit.
  always_ff @(posedge clk) begin
    if (dp_cmd.shift && !dp_status.shift_done) begin
      value_store[scan_slot]    <= value_store[src_slot];
      priority_store[scan_slot] <= priority_store[src_slot];
    end else if (dp_cmd.commit && cmd_q == uapq_pkg::CMD_INSERT && !full) begin
      value_store[tail_slot]    <= val_q;
      priority_store[tail_slot] <= pri_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      oldest_slot <= '0;
    end else if (dp_cmd.commit) begin
      if (cmd_q == uapq_pkg::CMD_INSERT) begin
        if (!full) begin
          entry_count <= entry_count + uapq_pkg::CNT_W'(1);
        end
      end else if (!empty) begin
        entry_count <= entry_count - uapq_pkg::CNT_W'(1);
        oldest_slot <= (entry_count == uapq_pkg::CNT_W'(1)) ? '0 : next_oldest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.commit) begin
      removed_value    <= '0;
      removed_priority <= '0;
      status           <= uapq_pkg::ST_DONE;
      if (cmd_q == uapq_pkg::CMD_INSERT) begin
        occupancy <= 4'(entry_count + (full ? uapq_pkg::CNT_W'(0) : uapq_pkg::CNT_W'(1)));
        if (full) begin
          status <= uapq_pkg::ST_FULL;
        end
      end else if (empty) begin
        status    <= uapq_pkg::ST_EMPTY;
        occupancy <= 4'(entry_count);
      end else begin
        removed_value    <= best_val;
        removed_priority <= 8'(best_pri);
        occupancy        <= 4'(entry_count - uapq_pkg::CNT_W'(1));
      end
    end
  end

endmodule
`default_nettype wire

### rtl/uapq_controller.sv
// Controller: sequences capture, minimum scan, gap shift and result commit.
`default_nettype none
module uapq_controller (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire uapq_pkg::dp_status_t dp_status,
  output uapq_pkg::dp_cmd_t         dp_cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_SCAN   = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    dp_cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.load = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = dp_status.del_go ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        dp_cmd.scan = 1'b1;
        if (dp_status.scan_last) begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        dp_cmd.shift = 1'b1;
        if (dp_status.shift_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // Hold until the result register is free.
        if (dp_status.out_free) begin
          dp_cmd.commit = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

### rtl/unsorted_array_priority_queue.sv
// Top level of the unsorted-array min-priority queue.
// Input channel (in_valid/in_ready): one beat carries cmd, value and
// priority_req. cmd insert appends the value with its priority; cmd delete
// removes the entry with the smallest priority number, the oldest on ties.
// Output channel (out_valid/out_ready): one beat per input beat, carrying
// status (done, full, empty), the removed value and priority (zero unless a
// delete succeeded) and the occupancy after the operation.
// Timing: one item at a time; a new beat is taken only after the last one is
// committed. An insert, a full insert or an empty delete goes from capture
// through the check state to commit. A delete then scans the held entries,
// one compare per held entry, then makes one store move per entry older than
// the minimum through the single write port, and then commits.
// Reset clears the entry count, oldest slot, controller and output valid;
// store contents are left as they are and are never read before written.
// A stalled receiver holds the result register; the block finishes the
// current item but does not commit it or take a new beat until the result
// register frees up.
`default_nettype none
module unsorted_array_priority_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               cmd,
  input  wire logic signed [31:0] value,
  input  wire logic [7:0]         priority_req,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status,
  output logic signed [31:0]      removed_value,
  output logic [7:0]              removed_priority,
  output logic [3:0]              occupancy
);

  uapq_pkg::dp_cmd_t    dp_cmd;
  uapq_pkg::dp_status_t dp_status;

  uapq_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd)
  );

  uapq_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .value            (value),
    .priority_req     (priority_req),
    .out_ready        (out_ready),
    .dp_cmd           (dp_cmd),
    .dp_status        (dp_status),
    .status           (status),
    .removed_value    (removed_value),
    .removed_priority (removed_priority),
    .occupancy        (occupancy),
    .out_valid        (out_valid)
  );

endmodule
`default_nettype wire

### test/tb_unsorted_array_priority_queue.sv
// Self-checking testbench for the unsorted-array min-priority queue.
`timescale 1ns / 100ps
`default_nettype none
module tb_unsorted_array_priority_queue;

  localparam logic [7:0] PRIO_MASK = 8'((64'd1 << uapq_pkg::PRIO_BITS) - 1);
  localparam int RANDOM_ITEMS = 500;

  typedef struct {
    uapq_pkg::cmd_t     op;
    logic signed [31:0] val;
    logic [7:0]         prio;
  } request_t;

  typedef struct {
    uapq_pkg::status_t  st;
    logic signed [31:0] val;
    logic [7:0]         prio;
    logic [3:0]         occ;
  } outcome_t;

  typedef struct {
    logic signed [31:0] val;
    logic [7:0]         prio;
  } entry_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               cmd = 1'b0;
  logic signed [31:0] value = '0;
  logic [7:0]         priority_req = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic signed [31:0] removed_value;
  logic [7:0]         removed_priority;
  logic [3:0]         occupancy;

  request_t pending_requests[$];
  outcome_t expected_outcomes[$];
  entry_t   held_entries[$];     // arrival order, oldest first
  logic     in_taken = 1'b0;
  int       beats_sent = 0;
  int       errors = 0;

  unsorted_array_priority_queue u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .cmd              (cmd),
    .value            (value),
    .priority_req     (priority_req),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .removed_value    (removed_value),
    .removed_priority (removed_priority),
    .occupancy        (occupancy)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Apply one operation to the held entries and return what the block must report.
  function automatic outcome_t serve_min_priority(request_t req);
    outcome_t res;
    entry_t   ent;
    int       best;
    res.st   = uapq_pkg::ST_DONE;
    res.val  = '0;
    res.prio = '0;
    if (req.op == uapq_pkg::CMD_INSERT) begin
      if (held_entries.size() >= uapq_pkg::DEPTH) begin
        res.st = uapq_pkg::ST_FULL;
      end else begin
        ent.val  = req.val;
        ent.prio = req.prio & PRIO_MASK;
        held_entries.push_back(ent);
      end
    end else if (held_entries.size() == 0) begin
      res.st = uapq_pkg::ST_EMPTY;
    end else begin
      best = 0;
      // strict compare keeps the oldest on ties
      for (int k = 1; k < held_entries.size(); k++) begin
        if (held_entries[k].prio < held_entries[best].prio) best = k;
      end
      res.val  = held_entries[best].val;
      res.prio = held_entries[best].prio;
      held_entries.delete(best);
    end
    res.occ = 4'(held_entries.size());
    return res;
  endfunction

  function automatic int idle_mode();
    return (beats_sent / 64) % 4;
  endfunction

  function automatic int sender_idle_pct();
    case (idle_mode())
      1: return 73;
      3: return 22;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case (idle_mode())
      2: return 73;
      3: return 22;
      default: return 0;
    endcase
  endfunction

  function automatic request_t make_req(uapq_pkg::cmd_t op, logic signed [31:0] v,
                                        logic [7:0] p);
    request_t r;
    r.op   = op;
    r.val  = v;
    r.prio = p;
    return r;
  endfunction

  // Driver: hold the beat until accepted, then advance or go idle.
  always @(negedge clk) begin
    request_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_requests.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
        req = pending_requests.pop_front();
        in_valid     <= 1'b1;
        cmd          <= req.op;
        value        <= req.val;
        priority_req <= req.prio;
        beats_sent   <= beats_sent + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct());
    end
  end

  // Monitor: predict on each input beat, check each output beat.
  always @(posedge clk) begin
    request_t req;
    outcome_t exp_res;
    if (!rst) begin
      if (in_valid && in_ready) begin
        req.op   = uapq_pkg::cmd_t'(cmd);
        req.val  = value;
        req.prio = priority_req;
        expected_outcomes.push_back(serve_min_priority(req));
      end
      if (out_valid && out_ready) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t: unexpected result beat status=%0d value=%0d prio=%0d occ=%0d",
                   $time, status, removed_value, removed_priority, occupancy);
          errors++;
        end else begin
          exp_res = expected_outcomes.pop_front();
          if (status !== exp_res.st) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_res.st, status);
            errors++;
          end
          if (removed_value !== exp_res.val) begin
            $display("%0t: removed_value expected %0d actual %0d",
                     $time, exp_res.val, removed_value);
            errors++;
          end
          if (removed_priority !== exp_res.prio) begin
            $display("%0t: removed_priority expected %0d actual %0d",
                     $time, exp_res.prio, removed_priority);
            errors++;
          end
          if (occupancy !== exp_res.occ) begin
            $display("%0t: occupancy expected %0d actual %0d", $time, exp_res.occ, occupancy);
            errors++;
          end
        end
      end
    end
    in_taken <= !rst && in_valid && in_ready;
  end

  initial begin
    int       ins_pct;
    logic [7:0] p;
    logic signed [31:0] v;

    // Directed: empty delete, field extremes, fill, full insert, ties, drain.
    pending_requests.push_back(make_req(uapq_pkg::CMD_DELETE, 32'sd0, 8'd0));
    pending_requests.push_back(make_req(uapq_pkg::CMD_INSERT, 32'sh7FFFFFFF, 8'd255));
    pending_requests.push_back(make_req(uapq_pkg::CMD_INSERT, 32'sh80000000, 8'd0));
    pending_requests.push_back(make_req(uapq_pkg::CMD_INSERT, -32'sd1, 8'd128));
    pending_requests.push_back(make_req(uapq_pkg::CMD_INSERT, 32'sd0, 8'd0));
    pending_requests.push_back(make_req(uapq_pkg::CMD_INSERT, 32'sd1, 8'd7));
    pending_requests.push_back(make_req(uapq_pkg::CMD_INSERT, 32'sd2, 8'd255));
    pending_requests.push_back(make_req(uapq_pkg::CMD_INSERT, 32'sd3, 8'd1));
    pending_requests.push_back(make_req(uapq_pkg::CMD_INSERT, 32'sd4, 8'd200));
    pending_requests.push_back(make_req(uapq_pkg::CMD_INSERT, 32'sh5A5A5A5A, 8'h55));
    for (int i = 0; i < uapq_pkg::DEPTH; i++) begin
      pending_requests.push_back(make_req(uapq_pkg::CMD_DELETE, 32'shFFFFFFFF, 8'hFF));
    end
    pending_requests.push_back(make_req(uapq_pkg::CMD_DELETE, 32'sd0, 8'd0));
    // Keep a few held while others leave and arrive, so the oldest slot moves.
    pending_requests.push_back(make_req(uapq_pkg::CMD_INSERT, 32'sd10, 8'd9));
    pending_requests.push_back(make_req(uapq_pkg::CMD_INSERT, 32'sd11, 8'd3));
    pending_requests.push_back(make_req(uapq_pkg::CMD_INSERT, 32'sd12, 8'd9));
    pending_requests.push_back(make_req(uapq_pkg::CMD_DELETE, 32'sd0, 8'd0));
    pending_requests.push_back(make_req(uapq_pkg::CMD_INSERT, 32'sd13, 8'd9));

    // Random: blocks with a drifting insert bias so the queue swings between empty and full.
    ins_pct = 50;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 25 == 0) begin
        case ($urandom_range(0, 2))
          0: ins_pct = 15;
          1: ins_pct = 50;
          default: ins_pct = 85;
        endcase
      end
      p = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
      case ($urandom_range(0, 15))
        0: v = 32'sh7FFFFFFF;
        1: v = 32'sh80000000;
        default: v = $urandom;
      endcase
      if ($urandom_range(0, 99) < ins_pct) begin
        pending_requests.push_back(make_req(uapq_pkg::CMD_INSERT, v, p));
      end else begin
        pending_requests.push_back(make_req(uapq_pkg::CMD_DELETE, v, p));
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_requests.size() > 0 || in_valid || expected_outcomes.size() > 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire
